// ----- rtl/cbdq_pkg.sv -----
`default_nettype none
package cbdq_pkg;

    localparam int DEPTH_DEFAULT = 128;
    localparam int CAP_W         = 8;
    localparam int CAP_RESET     = 128;
    localparam int WORD_W        = 32;

    typedef enum logic [2:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_REAR  = 3'd1,
        REQ_DEL_FRONT = 3'd2,
        REQ_DEL_REAR  = 3'd3,
        REQ_RD_FRONT  = 3'd4,
        REQ_RD_REAR   = 3'd5
    } req_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic signed [WORD_W-1:0] WORD_NONE = -32'sd1;

    // response of one request, as it leaves the control unit
    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] dout;
        logic                     use_mem;
        logic                     is_empty;
        logic                     is_full;
    } resp_t;

endpackage
`default_nettype wire

// ----- rtl/cbdq_mem.sv -----
`default_nettype none
module cbdq_mem #(
    parameter int DEPTH = cbdq_pkg::DEPTH_DEFAULT,
    parameter int IW    = $clog2(DEPTH)
) (
    input  wire                                    clk,
    input  wire                                    we,
    input  wire [IW-1:0]                           waddr,
    input  wire logic signed [cbdq_pkg::WORD_W-1:0] wdata,
    input  wire                                    re,
    input  wire [IW-1:0]                           raddr,
    output logic signed [cbdq_pkg::WORD_W-1:0]     rdata
);

    logic signed [cbdq_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/cbdq_ctrl.sv -----
`default_nettype none
module cbdq_ctrl #(
    parameter int DEPTH = cbdq_pkg::DEPTH_DEFAULT,
    parameter int IW    = $clog2(DEPTH)
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    accept,
    input  wire [2:0]                              req_type,
    input  wire                                    cfg_we,
    input  wire [cbdq_pkg::CAP_W-1:0]              cfg_wdata,
    output logic                                   mem_we,
    output logic [IW-1:0]                          mem_waddr,
    output logic                                   mem_re,
    output logic [IW-1:0]                          mem_raddr,
    output logic                                   done,
    output cbdq_pkg::resp_t                        resp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > cbdq_pkg::CAP_W) ? CW : cbdq_pkg::CAP_W;
    localparam int RESET_LAST =
        ((cbdq_pkg::CAP_RESET > DEPTH) ? DEPTH : cbdq_pkg::CAP_RESET) - 1;

    logic [IW-1:0]   front_reg, front_next;
    logic [IW-1:0]   rear_reg, rear_next;
    logic            empty_reg, empty_next;
    logic [IW-1:0]   last_reg, last_next;
    logic            done_reg;
    cbdq_pkg::resp_t resp_reg, resp_next;

    logic [XW-1:0]   cap_x;
    logic            full_now;
    logic [IW-1:0]   front_step_dn;
    logic [IW-1:0]   rear_step_up;

    function automatic logic [IW-1:0] step_up(input logic [IW-1:0] x,
                                              input logic [IW-1:0] last);
        logic [IW-1:0] r;
        r = (x == last) ? '0 : x + IW'(1);
        return r;
    endfunction

    function automatic logic [IW-1:0] step_dn(input logic [IW-1:0] x,
                                              input logic [IW-1:0] last);
        logic [IW-1:0] r;
        r = (x == '0) ? last : x - IW'(1);
        return r;
    endfunction

    // clamp the written capacity to 1..DEPTH and keep its last index
    always_comb
    begin
        cap_x = XW'(cfg_wdata);
        if (cap_x == '0)
        begin
            last_next = '0;
        end
        else if (cap_x > XW'(DEPTH))
        begin
            last_next = IW'(DEPTH - 1);
        end
        else
        begin
            last_next = IW'(cap_x - XW'(1));
        end
    end

    always_comb
    begin
        full_now      = !empty_reg && (step_up(rear_reg, last_reg) == front_reg);
        front_step_dn = step_dn(front_reg, last_reg);
        rear_step_up  = step_up(rear_reg, last_reg);

        front_next = front_reg;
        rear_next  = rear_reg;
        empty_next = empty_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        resp_next         = '0;
        resp_next.status  = cbdq_pkg::ST_OK;

        case (cbdq_pkg::req_t'(req_type))
            cbdq_pkg::REQ_INS_FRONT, cbdq_pkg::REQ_INS_REAR:
            begin
                if (full_now)
                begin
                    resp_next.status = cbdq_pkg::ST_OVERFLOW;
                end
                else if (empty_reg)
                begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b0;
                    mem_we     = accept;
                    mem_waddr  = '0;
                end
                else if (cbdq_pkg::req_t'(req_type) == cbdq_pkg::REQ_INS_FRONT)
                begin
                    front_next = front_step_dn;
                    mem_we     = accept;
                    mem_waddr  = front_step_dn;
                end
                else
                begin
                    rear_next = rear_step_up;
                    mem_we    = accept;
                    mem_waddr = rear_step_up;
                end
            end
            cbdq_pkg::REQ_DEL_FRONT, cbdq_pkg::REQ_DEL_REAR:
            begin
                if (empty_reg)
                begin
                    resp_next.status = cbdq_pkg::ST_UNDERFLOW;
                end
                else if (front_reg == rear_reg)
                begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b1;
                end
                else if (cbdq_pkg::req_t'(req_type) == cbdq_pkg::REQ_DEL_FRONT)
                begin
                    front_next = step_up(front_reg, last_reg);
                end
                else
                begin
                    rear_next = step_dn(rear_reg, last_reg);
                end
            end
            cbdq_pkg::REQ_RD_FRONT, cbdq_pkg::REQ_RD_REAR:
            begin
                if (empty_reg)
                begin
                    resp_next.status = cbdq_pkg::ST_UNDERFLOW;
                    resp_next.dout   = cbdq_pkg::WORD_NONE;
                end
                else
                begin
                    // word arrives from the store's registered read port in the next cycle
                    resp_next.use_mem = 1'b1;
                    mem_re            = accept;
                    mem_raddr         = (cbdq_pkg::req_t'(req_type) ==
                                         cbdq_pkg::REQ_RD_FRONT) ? front_reg : rear_reg;
                end
            end
            default:
            begin
                resp_next.status = cbdq_pkg::ST_OK;
            end
        endcase

        resp_next.is_empty = empty_next;
        resp_next.is_full  = !empty_next &&
                             (step_up(rear_next, last_reg) == front_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
            last_reg  <= IW'(RESET_LAST);
            done_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
            last_reg  <= last_next;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                empty_reg <= empty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            resp_reg <= resp_next;
        end
    end

    assign done = done_reg;
    assign resp = resp_reg;

endmodule
`default_nettype wire

// ----- rtl/circular_buffer_deque.sv -----
// Result: a request accepted at a clock edge gives its result, marked by
// done, during the following cycle, unless cfg_we is high at that edge.
// Throughput: one request per cycle; the single store port pair (one write,
// one registered read) is enough for every request type.
// Reset: deque empty, indices zero, capacity 128 (or DEPTH if smaller); store contents undefined.
// The receiver cannot stall: each result is valid for exactly one cycle.
`default_nettype none
module circular_buffer_deque #(
    parameter int DEPTH = cbdq_pkg::DEPTH_DEFAULT
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    start,
    output logic                                   busy,
    input  wire [2:0]                              req_type,
    input  wire logic signed [cbdq_pkg::WORD_W-1:0] data_in,
    input  wire                                    cfg_we,
    input  wire [cbdq_pkg::CAP_W-1:0]              cfg_wdata,
    output logic                                   done,
    output logic [1:0]                             status,
    output logic signed [cbdq_pkg::WORD_W-1:0]     data_out,
    output logic                                   is_empty,
    output logic                                   is_full
);

    localparam int IW = $clog2(DEPTH);

    logic                               accept;
    logic                               mem_we;
    logic [IW-1:0]                      mem_waddr;
    logic                               mem_re;
    logic [IW-1:0]                      mem_raddr;
    logic signed [cbdq_pkg::WORD_W-1:0] mem_rdata;
    cbdq_pkg::resp_t                    resp;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    cbdq_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (req_type),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .done      (done),
        .resp      (resp)
    );

    cbdq_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (data_in),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign status   = resp.status;
    assign data_out = resp.use_mem ? mem_rdata : resp.dout;
    assign is_empty = resp.is_empty;
    assign is_full  = resp.is_full;

endmodule
`default_nettype wire
